FILE: sv/cuckoo_find_or_insert_macros.svh
// assertion macros for the cuckoo find-or-insert block
`ifndef CUCKOO_FIND_OR_INSERT_MACROS_SVH
`define CUCKOO_FIND_OR_INSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define CFI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication whose consequent is checked in the next cycle
`define CFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cfi_pkg.sv
// shared types, constants and hash helpers of the cuckoo find-or-insert block
`timescale 1ns / 1ps
package cfi_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned KeyWords   = 2;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned HashW      = 32;
  localparam int unsigned SlotW      = KeyW + HashW;
  localparam int unsigned RoundsW    = 6;
  localparam logic [RoundsW-1:0] RoundsReset = 6'd32;
  localparam logic [31:0] MixMult    = 32'h5bd1e995;
  localparam int unsigned MixShift   = 12;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActFind   = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;

  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StMissing  = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StCleared  = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [31:0] key_hash;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        in_secondary;
    logic [9:0]  slot_index;
    logic [31:0] probe_total;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
  } slot_t;

  function automatic logic [KeyW-1:0] mask_key(logic [63:0] k);
    logic [63:0] m;
    m = (KeyWords >= 2) ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    return k & m;
  endfunction

  function automatic logic [IdxW-1:0] prim_idx(logic [HashW-1:0] h);
    return h[IdxW-1:0];
  endfunction

  // product of the tag term, registered before the xor
  function automatic logic [31:0] mix_prod(logic [HashW-1:0] h);
    logic [31:0] tag;
    tag = (h >> MixShift) + 32'd1;
    return tag * MixMult;
  endfunction

endpackage

FILE: sv/cfi_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module cfi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: sv/cuckoo_find_or_insert.sv
// top level of the two-table cuckoo find-or-insert block
//
//  channel | direction | handshake       | payload
//  --------+-----------+-----------------+-------------------------
//  req     | in        | req_valid/stall | cfi_pkg::req_t
//  rsp     | out       | rsp_valid/stall | cfi_pkg::rsp_t
//  cfg     | in        | cfg_valid/ready | max_rounds (6 bits)
//
// one item at a time; a lookup reads the primary slot and then the secondary slot;
// an insert that misses both moves entries, each move writing the primary and then
// the secondary memory, for up to max_rounds moves; both memories have registered read
// clear sweeps both memories one row per cycle; the same
// sweep runs after reset, during which no item is accepted
// a finished result sits in an output register; the next item is taken
// while it waits, and the engine holds only when the register is still full
`timescale 1ns / 1ps
`include "cuckoo_find_or_insert_macros.svh"
module cuckoo_find_or_insert (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_stall_o,
  input  cfi_pkg::req_t                    req_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_stall_i,
  output cfi_pkg::rsp_t                    rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [cfi_pkg::RoundsW-1:0]      cfg_data_i
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MIX   = 10'b0000000010, // product registered, primary read issued
    S_PRD   = 10'b0000000100, // primary data back
    S_SRD   = 10'b0000001000, // secondary data back
    S_PWR   = 10'b0000010000, // write carry to primary, read issued earlier
    S_SMIX  = 10'b0000100000, // mix for evicted hash
    S_SRD2  = 10'b0001000000, // secondary read of displacement
    S_PMV   = 10'b0010000000, // issue primary read of next position
    S_CLR   = 10'b0100000000, // clearing sweep
    S_OUT   = 10'b1000000000  // wait for output register
  } state_e;

  state_e state_q, state_d;

  // engine registers
  cfi_pkg::req_t                      req_q, req_d;
  logic [cfi_pkg::IdxW-1:0]           pidx_q, pidx_d, sidx_q, sidx_d;
  logic [31:0]                        prod_q, prod_d;
  logic [31:0]                        cnt_q, cnt_d;
  logic [cfi_pkg::RoundsW-1:0]        rounds_q, rounds_d;
  logic [cfi_pkg::RoundsW-1:0]        left_q, left_d;
  cfi_pkg::slot_t                     carry_q, carry_d;
  cfi_pkg::slot_t                     evict_q, evict_d;
  logic                               rsec_q, rsec_d;
  logic [cfi_pkg::IdxW-1:0]           ridx_q, ridx_d;
  logic [cfi_pkg::IdxW-1:0]           clr_q, clr_d;
  cfi_pkg::rsp_t                      res_q, res_d;

  // output register
  logic                               ovalid_q, ovalid_d;
  cfi_pkg::rsp_t                      obuf_q, obuf_d;

  // memory ports
  logic                               p_we, s_we;
  logic [cfi_pkg::IdxW-1:0]           p_addr, s_addr;
  cfi_pkg::slot_t                     p_wdata, s_wdata, p_rdata, s_rdata;

  cfi_ram #(.Width(cfi_pkg::SlotW), .Depth(cfi_pkg::TableDepth)) u_prim (
    .clk_i, .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wdata), .rdata_o(p_rdata)
  );
  cfi_ram #(.Width(cfi_pkg::SlotW), .Depth(cfi_pkg::TableDepth)) u_sec (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata)
  );

  logic req_fire, rsp_fire, out_free;
  assign rsp_fire    = ovalid_q && !rsp_stall_i;
  assign out_free    = !ovalid_q || rsp_fire;
  assign req_stall_o = (state_q != S_IDLE);
  assign req_fire    = req_valid_i && !req_stall_o;
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = ovalid_q;
  assign rsp_o       = obuf_q;

  always_comb begin
    rounds_d = rounds_q;
    if (cfg_valid_i) begin
      rounds_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= cfi_pkg::RoundsReset;
    end else begin
      rounds_q <= rounds_d;
    end
  end

  logic [cfi_pkg::KeyW-1:0] kq;
  logic [cfi_pkg::IdxW-1:0] xidx;
  assign kq = req_q.key;

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    pidx_d  = pidx_q;
    sidx_d  = sidx_q;
    prod_d  = prod_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    carry_d = carry_q;
    evict_d = evict_q;
    rsec_d  = rsec_q;
    ridx_d  = ridx_q;
    clr_d   = clr_q;
    res_d   = res_q;
    p_we    = 1'b0;
    s_we    = 1'b0;
    p_addr  = pidx_q;
    s_addr  = sidx_q;
    p_wdata = carry_q;
    s_wdata = evict_q;
    xidx    = '0;
    ovalid_d = rsp_fire ? 1'b0 : ovalid_q;
    obuf_d   = obuf_q;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          req_d.action   = req_i.action;
          req_d.key      = cfi_pkg::mask_key(req_i.key);
          req_d.key_hash = req_i.key_hash;
          prod_d         = cfi_pkg::mix_prod(req_i.key_hash);
          pidx_d         = cfi_pkg::prim_idx(req_i.key_hash);
          p_addr         = cfi_pkg::prim_idx(req_i.key_hash);
          if (req_i.action == cfi_pkg::ActClear) begin
            clr_d   = '0;
            cnt_d   = '0;
            state_d = S_CLR;
          end else begin
            state_d = S_MIX;
          end
        end
      end
      S_MIX: begin
        sidx_d  = cfi_pkg::prim_idx(req_q.key_hash ^ prod_q);
        s_addr  = cfi_pkg::prim_idx(req_q.key_hash ^ prod_q);
        state_d = S_PRD;
      end
      S_PRD: begin
        // primary data valid, secondary read under way
        if (req_q.action == cfi_pkg::ActInsert) cnt_d = cnt_q + 32'd1;
        if (p_rdata.key == kq) begin
          res_d   = '{status: cfi_pkg::StFound, in_secondary: 1'b0,
                      slot_index: 10'(pidx_q), probe_total: 32'd0};
          state_d = S_OUT;
        end else begin
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (s_rdata.key == kq) begin
          if (req_q.action == cfi_pkg::ActInsert) cnt_d = cnt_q + 32'd1;
          res_d   = '{status: cfi_pkg::StFound, in_secondary: 1'b1,
                      slot_index: 10'(sidx_q), probe_total: 32'd0};
          state_d = S_OUT;
        end else if (req_q.action != cfi_pkg::ActInsert) begin
          res_d   = '{status: cfi_pkg::StMissing, in_secondary: 1'b0,
                      slot_index: 10'd0, probe_total: 32'd0};
          state_d = S_OUT;
        end else begin
          cnt_d   = cnt_q + 32'd1;
          carry_d = '{key: kq, hash: req_q.key_hash};
          left_d  = (rounds_q == '0) ? cfi_pkg::RoundsW'(1) : rounds_q;
          p_addr  = pidx_q;
          state_d = S_PWR;
        end
      end
      S_PWR: begin
        // p_rdata holds occupant of pidx_q; write carry there
        p_we    = 1'b1;
        p_addr  = pidx_q;
        p_wdata = carry_q;
        if (carry_q.key == kq) begin
          rsec_d = 1'b0;
          ridx_d = pidx_q;
        end
        cnt_d   = cnt_q + 32'd1;
        evict_d = p_rdata;
        if (p_rdata.key[31:0] == 32'd0) begin
          res_d.status = cfi_pkg::StInserted;
          res_d.in_secondary = (carry_q.key == kq) ? 1'b0 : rsec_q;
          res_d.slot_index   = 10'((carry_q.key == kq) ? pidx_q : ridx_q);
          state_d = S_OUT;
        end else begin
          prod_d  = cfi_pkg::mix_prod(p_rdata.hash);
          state_d = S_SMIX;
        end
      end
      S_SMIX: begin
        xidx    = cfi_pkg::prim_idx(evict_q.hash ^ prod_q);
        sidx_d  = xidx;
        s_addr  = xidx;
        state_d = S_SRD2;
      end
      S_SRD2: begin
        s_we    = 1'b1;
        s_addr  = sidx_q;
        s_wdata = evict_q;
        if (evict_q.key == kq) begin
          rsec_d = 1'b1;
          ridx_d = sidx_q;
        end
        cnt_d   = cnt_q + 32'd1;
        carry_d = s_rdata;
        res_d.in_secondary = (evict_q.key == kq) ? 1'b1 : rsec_q;
        res_d.slot_index   = 10'((evict_q.key == kq) ? sidx_q : ridx_q);
        if (s_rdata.key[31:0] == 32'd0) begin
          res_d.status = cfi_pkg::StInserted;
          state_d = S_OUT;
        end else if (left_q == cfi_pkg::RoundsW'(1)) begin
          res_d.status = cfi_pkg::StFull;
          state_d = S_OUT;
        end else begin
          left_d  = left_q - cfi_pkg::RoundsW'(1);
          pidx_d  = cfi_pkg::prim_idx(s_rdata.hash);
          state_d = S_PMV;
        end
      end
      S_PMV: begin
        p_addr  = pidx_q;
        state_d = S_PWR;
      end
      S_CLR: begin
        p_we    = 1'b1;
        s_we    = 1'b1;
        p_addr  = clr_q;
        s_addr  = clr_q;
        p_wdata = '0;
        s_wdata = '0;
        clr_d   = clr_q + cfi_pkg::IdxW'(1);
        if (clr_q == cfi_pkg::IdxW'(cfi_pkg::TableDepth - 1)) begin
          res_d   = '{status: cfi_pkg::StCleared, in_secondary: 1'b0,
                      slot_index: 10'd0, probe_total: 32'd0};
          // sweep after reset produces no result
          state_d = (req_q.action == cfi_pkg::ActClear) ? S_OUT : S_IDLE;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          obuf_d   = res_q;
          obuf_d.probe_total = (res_q.status == cfi_pkg::StCleared) ? 32'd0 : cnt_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      req_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      req_q    <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    sidx_q  <= sidx_d;
    prod_q  <= prod_d;
    left_q  <= left_d;
    carry_q <= carry_d;
    evict_q <= evict_d;
    rsec_q  <= rsec_d;
    ridx_q  <= ridx_d;
    res_q   <= res_d;
    obuf_q  <= obuf_d;
  end

endmodule

FILE: sv/cfi_checker.sv
// port-level checker for the cuckoo find-or-insert block, bound to the top
`timescale 1ns / 1ps
`include "cuckoo_find_or_insert_macros.svh"
module cfi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_stall_o,
  input logic          rsp_valid_o,
  input logic          rsp_stall_i,
  input cfi_pkg::rsp_t rsp_o
);
  // a stalled result holds
  `CFI_ASSERT_NEXT(a_rsp_hold, rsp_valid_o && rsp_stall_i, rsp_valid_o && $stable(rsp_o), "rsp changed while stalled")
  // a cleared result reports zero count and slot
  `CFI_ASSERT(a_clear_zero, (rsp_valid_o && rsp_o.status == cfi_pkg::StCleared) |-> (rsp_o.probe_total == 32'd0 && rsp_o.slot_index == 10'd0), "clear result not zero")
  // a taken item keeps the input side busy next cycle
  `CFI_ASSERT_NEXT(a_busy, req_valid_i && !req_stall_o, req_stall_o, "accepted item did not block input")
  // status codes stay in range
  `CFI_ASSERT(a_status, rsp_valid_o |-> (rsp_o.status <= cfi_pkg::StCleared), "bad status")
endmodule

bind cuckoo_find_or_insert cfi_checker u_cfi_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .rsp_valid_o, .rsp_stall_i, .rsp_o
);
